// ===== rtl/core/fpat_pkg.sv =====
// Shared types and constants for the Q16.16 affine transform.
`timescale 1ns / 1ps
`default_nettype none

package fpat_pkg;

  // Q16.16 word and widths
  localparam int WORD_W      = 32;
  localparam int LANES       = 3;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int DATA_W      = LANES * WORD_W;

  typedef logic [WORD_W-1:0] word_t;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_WEIGHTS_XY      = 3'd0,
    REG_X_WEIGHT_Z_OFFSET = 3'd1,
    REG_Y_WEIGHTS_XY      = 3'd2,
    REG_Y_WEIGHT_Z_OFFSET = 3'd3,
    REG_Z_WEIGHTS_XY      = 3'd4,
    REG_Z_WEIGHT_Z_OFFSET = 3'd5
  } reg_index_t;

  // Reset values: identity matrix, zero offset
  localparam logic [CFG_DATA_W-1:0] RST_X_WEIGHTS_XY      = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_X_WEIGHT_Z_OFFSET = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_Y_WEIGHTS_XY      = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_Y_WEIGHT_Z_OFFSET = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_Z_WEIGHTS_XY      = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_Z_WEIGHT_Z_OFFSET = 64'h0000_0000_0001_0000;

  // Item moving along the chain: v[0] is the component for the next cell,
  // acc holds the running sum of each result lane.
  typedef struct packed {
    word_t [LANES-1:0] v;
    word_t [LANES-1:0] acc;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/fpat_cell.sv =====
// One cell of the transform chain: scales one vector component into three lanes.
`timescale 1ns / 1ps
`default_nettype none

module fpat_cell
  import fpat_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // weight of this cell's component into each result lane
  input  wire word_t [LANES-1:0]      w,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire item_t                  in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output item_t                       out_item
);

  localparam int PROD_W = 2 * WORD_W;

  logic                    p_vld;
  word_t [LANES-1:0]       p_vec;
  word_t [LANES-1:0]       p_acc;
  word_t [LANES-1:0]       p_prod;
  logic                    s2_ready;
  logic signed [PROD_W-1:0] prod [LANES];

  // Full signed products of the head component
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      prod[j] = $signed(in_item.v[0]) * $signed(w[j]);
    end
  end

  // Stage ready: a stage takes new data when empty or when it drains
  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !p_vld || s2_ready;

  // Product stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (in_ready) begin
      p_vld <= in_valid;
    end
  end

  // Product stage payload: keep bits 16..47 of each product, shift vector down
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int j = 0; j < LANES; j++) begin
        p_prod[j] <= prod[j][FRAC_BITS +: WORD_W];
      end
      p_acc <= in_item.acc;
      p_vec <= {word_t'(0), in_item.v[LANES-1:1]};
    end
  end

  // Sum stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= p_vld;
    end
  end

  // Sum stage payload: wrapping add into each lane
  always_ff @(posedge clk) begin
    if (s2_ready && p_vld) begin
      for (int j = 0; j < LANES; j++) begin
        out_item.acc[j] <= p_acc[j] + p_prod[j];
      end
      out_item.v <= p_vec;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fixed_point_affine_transform.sv =====
// Top level of the Q16.16 affine 3x4 matrix-vector transform.
//
//  channel   direction  handshake                   payload
//  s_*       in         s_tvalid / s_tready         s_tdata: vx, vy, vz
//  m_*       out        m_tvalid / m_tready         m_tdata: rx, ry, rz
//  cfg_*     in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One vector per cycle while m_tready is high; two register stages (multiply,
// add) in each of three cells, one cell per input component.
// Each stage has its own valid, so empty stages fill while the output stalls.
// Reset loads the identity matrix with zero offset and empties the chain.
// Config writes are always taken; indexes beyond the list are ignored.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_affine_transform
  import fpat_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input vectors
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [DATA_W-1:0]      s_tdata,   // vx [31:0], vy [63:32], vz [95:64]
  // results
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [DATA_W-1:0]           m_tdata,   // rx [31:0], ry [63:32], rz [95:64]
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0] x_weights_xy;
  logic [CFG_DATA_W-1:0] x_weight_z_offset;
  logic [CFG_DATA_W-1:0] y_weights_xy;
  logic [CFG_DATA_W-1:0] y_weight_z_offset;
  logic [CFG_DATA_W-1:0] z_weights_xy;
  logic [CFG_DATA_W-1:0] z_weight_z_offset;

  word_t [LANES-1:0] col_w [LANES];
  logic              c_valid [LANES+1];
  logic              c_ready [LANES+1];
  item_t             c_item  [LANES+1];

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      x_weights_xy      <= RST_X_WEIGHTS_XY;
      x_weight_z_offset <= RST_X_WEIGHT_Z_OFFSET;
      y_weights_xy      <= RST_Y_WEIGHTS_XY;
      y_weight_z_offset <= RST_Y_WEIGHT_Z_OFFSET;
      z_weights_xy      <= RST_Z_WEIGHTS_XY;
      z_weight_z_offset <= RST_Z_WEIGHT_Z_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_WEIGHTS_XY:      x_weights_xy      <= cfg_data;
        REG_X_WEIGHT_Z_OFFSET: x_weight_z_offset <= cfg_data;
        REG_Y_WEIGHTS_XY:      y_weights_xy      <= cfg_data;
        REG_Y_WEIGHT_Z_OFFSET: y_weight_z_offset <= cfg_data;
        REG_Z_WEIGHTS_XY:      z_weights_xy      <= cfg_data;
        REG_Z_WEIGHT_Z_OFFSET: z_weight_z_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Weight columns: cell k gets the weights of component k into rx, ry, rz
  assign col_w[0] = {z_weights_xy[WORD_W-1:0], y_weights_xy[WORD_W-1:0],
                     x_weights_xy[WORD_W-1:0]};
  assign col_w[1] = {z_weights_xy[CFG_DATA_W-1:WORD_W], y_weights_xy[CFG_DATA_W-1:WORD_W],
                     x_weights_xy[CFG_DATA_W-1:WORD_W]};
  assign col_w[2] = {z_weight_z_offset[WORD_W-1:0], y_weight_z_offset[WORD_W-1:0],
                     x_weight_z_offset[WORD_W-1:0]};

  // Chain entry: vector in, sums seeded with the offsets
  assign c_valid[0]    = s_tvalid;
  assign s_tready      = c_ready[0];
  assign c_item[0].v   = s_tdata;
  assign c_item[0].acc = {z_weight_z_offset[CFG_DATA_W-1:WORD_W],
                          y_weight_z_offset[CFG_DATA_W-1:WORD_W],
                          x_weight_z_offset[CFG_DATA_W-1:WORD_W]};

  // Row of cells
  for (genvar k = 0; k < LANES; k++) begin : g_cell
    fpat_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .w         (col_w[k]),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .in_item   (c_item[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .out_item  (c_item[k+1])
    );
  end

  // Chain exit
  assign m_tvalid       = c_valid[LANES];
  assign c_ready[LANES] = m_tready;
  assign m_tdata        = c_item[LANES].acc;

endmodule

`default_nettype wire

// ===== verif/fixed_point_affine_transform_test.sv =====
// Self-checking testbench for the Q16.16 affine 3x4 matrix-vector transform.
`timescale 1ns / 1ps

module fixed_point_affine_transform_test;
  import fpat_pkg::*;

  localparam int NUM_REGS     = 6;
  localparam int TOP_INDEX    = (1 << CFG_INDEX_W) - 1;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_GAP      = 14;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int SRC          = 0;
  localparam int SNK          = 1;

  // Q16.16 reference points
  localparam word_t Q_ZERO    = 32'h0000_0000;
  localparam word_t Q_ONE     = 32'h0001_0000;
  localparam word_t Q_NEG_ONE = 32'hFFFF_0000;
  localparam word_t Q_MAX     = 32'h7FFF_FFFF;
  localparam word_t Q_MIN     = 32'h8000_0000;
  localparam word_t Q_LSB     = 32'h0000_0001;
  localparam word_t ALL_ONES  = 32'hFFFF_FFFF;

  // One vector; x sits in the lowest bits, as on tdata
  typedef struct packed {
    word_t z;
    word_t y;
    word_t x;
  } q_vec_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata   = '0;   // vx [31:0], vy [63:32], vz [95:64]
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [DATA_W-1:0]      m_tdata;          // rx [31:0], ry [63:32], rz [95:64]
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Local copy of the matrix registers and results still owed by the block
  logic [CFG_DATA_W-1:0] matrix_copy [NUM_REGS];
  q_vec_t                pending_results [$];
  int unsigned           error_count = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           calm_left [2] = '{0, 0};

  fixed_point_affine_transform uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Bits 16..47 of the full signed product, no rounding
  function automatic word_t q_product(word_t a, word_t b);
    logic [63:0] p;
    p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
    return p[47:16];
  endfunction

  // One result lane; sums wrap at 32 bits
  function automatic word_t lane_sum(q_vec_t v, logic [CFG_DATA_W-1:0] wxy,
                                     logic [CFG_DATA_W-1:0] wzo);
    return q_product(v.x, wxy[31:0]) + q_product(v.y, wxy[63:32])
         + q_product(v.z, wzo[31:0]) + wzo[63:32];
  endfunction

  function automatic q_vec_t transform_vector(q_vec_t v);
    q_vec_t r;
    r.x = lane_sum(v, matrix_copy[REG_X_WEIGHTS_XY], matrix_copy[REG_X_WEIGHT_Z_OFFSET]);
    r.y = lane_sum(v, matrix_copy[REG_Y_WEIGHTS_XY], matrix_copy[REG_Y_WEIGHT_Z_OFFSET]);
    r.z = lane_sum(v, matrix_copy[REG_Z_WEIGHTS_XY], matrix_copy[REG_Z_WEIGHT_Z_OFFSET]);
    return r;
  endfunction

  // Idle cycles before a transfer; occasional runs with no idling at all
  function automatic int unsigned pick_gap(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Mix of extremes, small Q16.16 values and full-range words
  function automatic word_t rand_word();
    word_t r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return ($urandom_range(0, 1) != 0) ? Q_ONE : Q_NEG_ONE;
      3:       return ($urandom_range(0, 1) != 0) ? Q_ZERO : ALL_ONES;
      4, 5, 6: return {{8{r[23]}}, r[23:0]};
      default: return r;
    endcase
  endfunction

  // Register write; cfg_valid stays high unless this is the last of a batch
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value, input bit last);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index < NUM_REGS)
      matrix_copy[index] = value;
    if (last) begin
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  // Odd indexes hold {offset, z weight}, even ones {y weight, x weight}
  task automatic load_uniform(input word_t weight, input word_t offset);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(CFG_INDEX_W'(i), (i % 2 != 0) ? {offset, weight} : {weight, weight},
                i == NUM_REGS - 1);
  endtask

  task automatic load_random_matrix();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(CFG_INDEX_W'(i), {rand_word(), rand_word()}, i == NUM_REGS - 1);
  endtask

  // Send one vector; the expected result is queued on the transfer
  task automatic send_vector(input word_t vx, input word_t vy, input word_t vz);
    int unsigned gap;
    q_vec_t      v;
    gap = pick_gap(SRC);
    v   = '{z: vz, y: vy, x: vx};
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(transform_vector(v));
  endtask

  // Stop sending and let every owed result come out
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic test_reset_identity();
    send_vector(Q_ZERO, Q_ZERO, Q_ZERO);
    send_vector(Q_MAX, Q_MIN, ALL_ONES);
    send_vector(Q_MIN, Q_MAX, Q_LSB);
    send_vector(Q_ONE, Q_NEG_ONE, Q_ONE);
    send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
  endtask

  // Extreme weights and offsets against extreme vectors: products and sums wrap
  task automatic test_extreme_matrices();
    for (int m = 0; m < 3; m++) begin
      case (m)
        0:       load_uniform(Q_MAX, Q_MAX);
        1:       load_uniform(Q_MIN, Q_MIN);
        default: load_uniform(ALL_ONES, Q_NEG_ONE);
      endcase
      send_vector(Q_MAX, Q_MAX, Q_MAX);
      send_vector(Q_MIN, Q_MIN, Q_MIN);
      send_vector(Q_MIN, Q_MAX, ALL_ONES);
      send_vector(Q_ONE, Q_NEG_ONE, Q_ONE);
      drain();
    end
  endtask

  // Writes beyond the register list must leave the matrix alone
  task automatic test_ignored_index();
    load_random_matrix();
    write_reg(CFG_INDEX_W'(NUM_REGS), {$urandom, $urandom}, 1'b0);
    write_reg(CFG_INDEX_W'(TOP_INDEX), {$urandom, $urandom}, 1'b1);
    send_vector(Q_ONE, Q_ONE, Q_ONE);
    send_vector(rand_word(), rand_word(), rand_word());
    drain();
  endtask

  task automatic test_random_transforms();
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_random_matrix();
      repeat (PHASE_ITEMS)
        send_vector(rand_word(), rand_word(), rand_word());
      drain();
    end
  endtask

  // Result side: random stalls, then hold tready until a transfer
  initial begin : result_sink
    int unsigned gap;
    forever begin
      gap = pick_gap(SNK);
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready && !rst));
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    q_vec_t got;
    q_vec_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        $error("unexpected result: rx %h ry %h rz %h", got.x, got.y, got.z);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.x !== want.x) begin
          $error("rx mismatch: expected %h, got %h", want.x, got.x);
          error_count++;
        end
        if (got.y !== want.y) begin
          $error("ry mismatch: expected %h, got %h", want.y, got.y);
          error_count++;
        end
        if (got.z !== want.z) begin
          $error("rz mismatch: expected %h, got %h", want.z, got.z);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("fixed_point_affine_transform_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    matrix_copy[REG_X_WEIGHTS_XY]      = RST_X_WEIGHTS_XY;
    matrix_copy[REG_X_WEIGHT_Z_OFFSET] = RST_X_WEIGHT_Z_OFFSET;
    matrix_copy[REG_Y_WEIGHTS_XY]      = RST_Y_WEIGHTS_XY;
    matrix_copy[REG_Y_WEIGHT_Z_OFFSET] = RST_Y_WEIGHT_Z_OFFSET;
    matrix_copy[REG_Z_WEIGHTS_XY]      = RST_Z_WEIGHTS_XY;
    matrix_copy[REG_Z_WEIGHT_Z_OFFSET] = RST_Z_WEIGHT_Z_OFFSET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_identity();
    test_extreme_matrices();
    test_ignored_index();
    test_random_transforms();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("fixed_point_affine_transform_test: clean");
    end else begin
      $display("fixed_point_affine_transform_test: errors");
    end
    $finish;
  end

endmodule
